// ===== hdl/patch_moment_projection_top_assert.svh =====
// ----------------------------------------------------------------------------
// Patch moment projection assertion macros
// Shared forms for the concurrent checks on the top level ports.
// ----------------------------------------------------------------------------
`ifndef PATCH_MOMENT_PROJECTION_TOP_ASSERT_SVH
`define PATCH_MOMENT_PROJECTION_TOP_ASSERT_SVH

// check a property while out of reset
`define PMP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check a property at every edge, reset included
`define PMP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/pmp_pkg.sv =====
// ----------------------------------------------------------------------------
// Patch moment projection package
// Field widths, register indexes and default sizes shared by the block.
// ----------------------------------------------------------------------------
package pmp_pkg;

    localparam int DEF_MAX_FEATURES = 8;
    localparam int DEF_MAX_PATCH    = 16;
    localparam int DEF_MAX_WIDTH    = 1024;
    localparam int DEF_MAX_HEIGHT   = 1024;

    localparam int PIX_W   = 8;
    localparam int SEL_W   = 3;
    localparam int KPOS_W  = 4;
    localparam int COEF_W  = 16;
    localparam int FV_W    = 40;
    localparam int FIDX_W  = 3;
    localparam int PIDX_W  = 9;
    localparam int CFG_DW  = 11;
    localparam int CFG_IW  = 2;
    localparam int PROD_W  = PIX_W + COEF_W + 1;

    localparam logic [CFG_IW-1:0] REG_IMAGE_WIDTH     = 2'd0;
    localparam logic [CFG_IW-1:0] REG_IMAGE_HEIGHT    = 2'd1;
    localparam logic [CFG_IW-1:0] REG_PATCH_SIZE      = 2'd2;
    localparam logic [CFG_IW-1:0] REG_FEATURES_IN_USE = 2'd3;

    localparam int RST_WIDTH    = 64;
    localparam int RST_HEIGHT   = 64;
    localparam int RST_PATCH    = 8;
    localparam int RST_FEATURES = 7;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPW         = 2;
    localparam int QCW         = 3;

endpackage

// ===== hdl/patch_moment_projection_top.sv =====
// ----------------------------------------------------------------------------
// Patch moment projection top level
// Projects square image patches onto stored kernels and streams the sums.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_stall): command 0 loads one kernel coefficient,
// command 1 carries one raster-order pixel. A transfer happens when i_valid is
// high and o_stall low. One item per cycle is taken; a load never stalls for
// its own sake, but every item waits while the patch queue plus the patches in
// flight fill its four slots.
// Output channel (o_valid / i_stall): after the last pixel of a complete
// patch, one result per kernel in use follows in kernel order, one per cycle
// while the receiver does not stall. The three-stage read-multiply-accumulate
// pipeline runs over the kernel memory and the accumulator memory; the
// accumulator write port sets the rate of one pixel a cycle. While the
// receiver stalls the result holds and up to four finished patches queue up
// before input stalls.
// Reset restores the register defaults, restarts the raster at pixel (0,0) and
// empties the queue; kernel tables are not cleared. Any register write also
// restarts the raster.
// ----------------------------------------------------------------------------
module patch_moment_projection_top #(
    parameter int MAX_FEATURES = pmp_pkg::DEF_MAX_FEATURES,
    parameter int MAX_PATCH    = pmp_pkg::DEF_MAX_PATCH,
    parameter int MAX_WIDTH    = pmp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT   = pmp_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [pmp_pkg::CFG_IW-1:0]          i_cfg_index,
    input  logic [pmp_pkg::CFG_DW-1:0]          i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_command,
    input  logic [pmp_pkg::PIX_W-1:0]           i_pixel_value,
    input  logic [pmp_pkg::SEL_W-1:0]           i_kernel_select,
    input  logic [pmp_pkg::KPOS_W-1:0]          i_kernel_row,
    input  logic [pmp_pkg::KPOS_W-1:0]          i_kernel_col,
    input  logic signed [pmp_pkg::COEF_W-1:0]   i_kernel_value,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [pmp_pkg::FV_W-1:0]     o_feature_value,
    output logic [pmp_pkg::FIDX_W-1:0]          o_feature_index,
    output logic [pmp_pkg::PIDX_W-1:0]          o_patch_row_index,
    output logic [pmp_pkg::PIDX_W-1:0]          o_patch_col_index,
    output logic                                o_last_of_patch,
    output logic                                o_last_of_frame
);

    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int HW   = $clog2(MAX_HEIGHT + 1);
    localparam int PSW  = $clog2(MAX_PATCH + 1);
    localparam int PW   = $clog2(MAX_PATCH);
    localparam int NFW  = $clog2(MAX_FEATURES + 1);
    localparam int FW   = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int AW   = $clog2(MAX_WIDTH / 2);
    localparam int CW   = $clog2(MAX_WIDTH / 2 + 1);
    localparam int RW   = $clog2(MAX_HEIGHT / 2 + 1);
    localparam int XW   = ((WW > HW) ? WW : HW) + 2;
    localparam int KD   = 1 << (2 * PW);
    localparam int AD   = 1 << AW;
    localparam int KLW  = MAX_FEATURES * pmp_pkg::COEF_W;
    localparam int ALW  = MAX_FEATURES * pmp_pkg::FV_W;
    localparam int RSTW = (pmp_pkg::RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH : pmp_pkg::RST_WIDTH;
    localparam int RSTH = (pmp_pkg::RST_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT
                                                             : pmp_pkg::RST_HEIGHT;
    localparam int RSTP = (pmp_pkg::RST_PATCH > MAX_PATCH) ? MAX_PATCH : pmp_pkg::RST_PATCH;
    localparam int RSTF = (pmp_pkg::RST_FEATURES > MAX_FEATURES) ? MAX_FEATURES
                                                                 : pmp_pkg::RST_FEATURES;

    typedef struct packed {
        logic                          valid;
        logic                          first;
        logic                          last;
        logic                          fend;
        logic [AW-1:0]                 addr;
        logic [pmp_pkg::PIDX_W-1:0]    prow;
        logic [pmp_pkg::PIDX_W-1:0]    pcol;
    } t_ctl;

    typedef struct packed {
        logic                          valid;
        logic [AW-1:0]                 addr;
        logic [ALW-1:0]                sums;
    } t_wr;

    typedef struct packed {
        logic [ALW-1:0]                sums;
        logic [pmp_pkg::PIDX_W-1:0]    prow;
        logic [pmp_pkg::PIDX_W-1:0]    pcol;
        logic                          fend;
    } t_rec;

    // configuration
    logic [WW-1:0]  r_width;
    logic [HW-1:0]  r_height;
    logic [PSW-1:0] r_psize;
    logic [NFW-1:0] r_nf;

    // raster position
    logic [WW-1:0]  r_col, n_col, r_pcol_start, n_pcol_start;
    logic [HW-1:0]  r_row, n_row, r_prow_start, n_prow_start;
    logic [PW-1:0]  r_ocol, n_ocol, r_orow, n_orow;
    logic [CW-1:0]  r_cpc, n_cpc;
    logic [RW-1:0]  r_cpr, n_cpr;

    // memories
    logic [KLW-1:0] r_kmem [KD];
    logic [ALW-1:0] r_amem [AD];
    logic [KLW-1:0] r_kq;
    logic [ALW-1:0] r_aq;

    // pipeline
    t_ctl r_s1, r_s2, s0;
    t_wr  r_w1, r_w2;
    logic [pmp_pkg::PIX_W-1:0]          r_pix1;
    logic [ALW-1:0]                     r_base;
    logic signed [pmp_pkg::PROD_W-1:0]  r_prod [MAX_FEATURES];
    logic [ALW-1:0]                     s2_sums;

    // patch queue and serializer
    t_rec                   r_q [pmp_pkg::QUEUE_DEPTH];
    logic [pmp_pkg::QPW-1:0] r_wp, r_rp;
    logic [pmp_pkg::QCW-1:0] r_occ;
    logic [FW-1:0]          r_kidx;
    t_rec                   head;

    logic in_acc, pix_acc, load_acc, push, pop, fin;
    logic in_patch, col_last, row_last;
    logic [pmp_pkg::QCW-1:0] inflight;
    logic [XW-1:0] ps_x;
    logic [2*PW-1:0] kwr_addr;
    int unsigned cfg_d;
    logic [WW-1:0]  cfg_w;
    logic [HW-1:0]  cfg_h;
    logic [PSW-1:0] cfg_p;
    logic [NFW-1:0] cfg_f;

    assign inflight = pmp_pkg::QCW'(r_s1.valid & r_s1.last)
                    + pmp_pkg::QCW'(r_s2.valid & r_s2.last);
    assign o_stall  = (r_occ + inflight) >= pmp_pkg::QCW'(pmp_pkg::QUEUE_DEPTH);
    assign in_acc   = i_valid && !o_stall;
    assign pix_acc  = in_acc && i_command;
    assign load_acc = in_acc && !i_command;

    // register clamping
    always_comb begin
        cfg_d = 32'(i_cfg_data);
        cfg_w = WW'((cfg_d < 1) ? 1 : (cfg_d > MAX_WIDTH) ? MAX_WIDTH : cfg_d);
        cfg_h = HW'((cfg_d < 1) ? 1 : (cfg_d > MAX_HEIGHT) ? MAX_HEIGHT : cfg_d);
        cfg_p = PSW'((cfg_d < 2) ? 2 : (cfg_d > MAX_PATCH) ? MAX_PATCH : cfg_d);
        cfg_f = NFW'((cfg_d < 1) ? 1 : (cfg_d > MAX_FEATURES) ? MAX_FEATURES : cfg_d);
    end

    // patch membership and raster advance
    always_comb begin
        ps_x     = XW'(r_psize);
        in_patch = (XW'(r_pcol_start) + ps_x <= XW'(r_width))
                && (XW'(r_prow_start) + ps_x <= XW'(r_height));
        col_last = XW'(r_pcol_start) + ps_x + ps_x > XW'(r_width);
        row_last = XW'(r_prow_start) + ps_x + ps_x > XW'(r_height);

        s0.valid = pix_acc && in_patch;
        s0.first = (r_ocol == '0) && (r_orow == '0);
        s0.last  = (PSW'(r_ocol) + PSW'(1) == r_psize) && (PSW'(r_orow) + PSW'(1) == r_psize);
        s0.fend  = col_last && row_last;
        s0.addr  = AW'(r_cpc);
        s0.prow  = pmp_pkg::PIDX_W'(r_cpr);
        s0.pcol  = pmp_pkg::PIDX_W'(r_cpc);

        n_col        = r_col + WW'(1);
        n_ocol       = r_ocol + PW'(1);
        n_cpc        = r_cpc;
        n_pcol_start = r_pcol_start;
        n_row        = r_row;
        n_orow       = r_orow;
        n_cpr        = r_cpr;
        n_prow_start = r_prow_start;
        if (PSW'(r_ocol) + PSW'(1) >= r_psize) begin
            n_ocol       = '0;
            n_cpc        = r_cpc + CW'(1);
            n_pcol_start = r_pcol_start + WW'(r_psize);
        end
        if (n_col >= r_width) begin
            n_col        = '0;
            n_ocol       = '0;
            n_cpc        = '0;
            n_pcol_start = '0;
            n_row        = r_row + HW'(1);
            n_orow       = r_orow + PW'(1);
            if (PSW'(r_orow) + PSW'(1) >= r_psize) begin
                n_orow       = '0;
                n_cpr        = r_cpr + RW'(1);
                n_prow_start = r_prow_start + HW'(r_psize);
            end
            if (n_row >= r_height) begin
                n_row        = '0;
                n_orow       = '0;
                n_cpr        = '0;
                n_prow_start = '0;
            end
        end
    end

    // kernel write lane
    always_comb begin
        kwr_addr = {PW'(i_kernel_row), PW'(i_kernel_col)};
    end

    // accumulate with forwarding from the two writes the read missed
    always_comb begin
        logic [pmp_pkg::FV_W-1:0] base;
        logic [pmp_pkg::FV_W-1:0] term;
        for (int k = 0; k < MAX_FEATURES; k++) begin
            if (r_w1.valid && r_w1.addr == r_s2.addr) begin
                base = r_w1.sums[k*pmp_pkg::FV_W +: pmp_pkg::FV_W];
            end else if (r_w2.valid && r_w2.addr == r_s2.addr) begin
                base = r_w2.sums[k*pmp_pkg::FV_W +: pmp_pkg::FV_W];
            end else begin
                base = r_base[k*pmp_pkg::FV_W +: pmp_pkg::FV_W];
            end
            term = pmp_pkg::FV_W'(r_prod[k]);
            s2_sums[k*pmp_pkg::FV_W +: pmp_pkg::FV_W] = r_s2.first ? term : base + term;
        end
    end

    // output from the queue head
    assign head              = r_q[r_rp];
    assign o_valid           = r_occ != '0;
    assign fin               = (NFW'(r_kidx) + NFW'(1)) == r_nf;
    assign o_feature_value   = head.sums[r_kidx*pmp_pkg::FV_W +: pmp_pkg::FV_W];
    assign o_feature_index   = pmp_pkg::FIDX_W'(r_kidx);
    assign o_patch_row_index = head.prow;
    assign o_patch_col_index = head.pcol;
    assign o_last_of_patch   = fin;
    assign o_last_of_frame   = fin && head.fend;
    assign push              = r_s2.valid && r_s2.last;
    assign pop               = o_valid && !i_stall && fin;

    // memories and payload
    always_ff @(posedge i_clk) begin
        if (load_acc && 32'(i_kernel_select) < MAX_FEATURES
                && 32'(i_kernel_row) < MAX_PATCH && 32'(i_kernel_col) < MAX_PATCH) begin
            // write only the lane of the selected kernel
            for (int k = 0; k < MAX_FEATURES; k++) begin
                if (32'(i_kernel_select) == k) begin
                    r_kmem[kwr_addr][k*pmp_pkg::COEF_W +: pmp_pkg::COEF_W] <= i_kernel_value;
                end
            end
        end
        r_kq <= r_kmem[{r_orow, r_ocol}];
        r_aq <= r_amem[s0.addr];
        if (r_s2.valid) begin
            r_amem[r_s2.addr] <= s2_sums;
        end
        r_pix1 <= i_pixel_value;
        r_base <= r_aq;
        for (int k = 0; k < MAX_FEATURES; k++) begin
            r_prod[k] <= $signed({1'b0, r_pix1})
                       * $signed(r_kq[k*pmp_pkg::COEF_W +: pmp_pkg::COEF_W]);
        end
        r_w1.valid <= i_rst_n && r_s2.valid;
        r_w1.addr  <= r_s2.addr;
        r_w1.sums  <= s2_sums;
        r_w2.valid <= i_rst_n && r_w1.valid;
        r_w2.addr  <= r_w1.addr;
        r_w2.sums  <= r_w1.sums;
        if (push) begin
            r_q[r_wp] <= '{sums: s2_sums, prow: r_s2.prow, pcol: r_s2.pcol, fend: r_s2.fend};
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width      <= WW'(RSTW);
            r_height     <= HW'(RSTH);
            r_psize      <= PSW'(RSTP);
            r_nf         <= NFW'(RSTF);
            r_col        <= '0;
            r_row        <= '0;
            r_ocol       <= '0;
            r_orow       <= '0;
            r_cpc        <= '0;
            r_cpr        <= '0;
            r_pcol_start <= '0;
            r_prow_start <= '0;
            r_s1         <= '0;
            r_s2         <= '0;
            r_wp         <= '0;
            r_rp         <= '0;
            r_occ        <= '0;
            r_kidx       <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    pmp_pkg::REG_IMAGE_WIDTH:     r_width  <= cfg_w;
                    pmp_pkg::REG_IMAGE_HEIGHT:    r_height <= cfg_h;
                    pmp_pkg::REG_PATCH_SIZE:      r_psize  <= cfg_p;
                    pmp_pkg::REG_FEATURES_IN_USE: r_nf     <= cfg_f;
                endcase
                r_col        <= '0;
                r_row        <= '0;
                r_ocol       <= '0;
                r_orow       <= '0;
                r_cpc        <= '0;
                r_cpr        <= '0;
                r_pcol_start <= '0;
                r_prow_start <= '0;
            end else if (pix_acc) begin
                r_col        <= n_col;
                r_row        <= n_row;
                r_ocol       <= n_ocol;
                r_orow       <= n_orow;
                r_cpc        <= n_cpc;
                r_cpr        <= n_cpr;
                r_pcol_start <= n_pcol_start;
                r_prow_start <= n_prow_start;
            end
            r_s1       <= s0;
            r_s2       <= r_s1;
            if (push) begin
                r_wp <= r_wp + pmp_pkg::QPW'(1);
            end
            if (o_valid && !i_stall) begin
                // advance through the kernels, drop the patch after the last
                if (fin) begin
                    r_kidx <= '0;
                    r_rp   <= r_rp + pmp_pkg::QPW'(1);
                end else begin
                    r_kidx <= r_kidx + FW'(1);
                end
            end
            r_occ <= r_occ + pmp_pkg::QCW'(push) - pmp_pkg::QCW'(pop);
        end
    end

endmodule

// ===== hdl/pmp_checker.sv =====
// ----------------------------------------------------------------------------
// Patch moment projection port checker
// Watches the result channel of the top level over time.
// ----------------------------------------------------------------------------
`include "patch_moment_projection_top_assert.svh"

module pmp_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_valid,
    input logic                              i_stall,
    input logic [pmp_pkg::FIDX_W-1:0]        o_feature_index,
    input logic [pmp_pkg::PIDX_W-1:0]        o_patch_col_index,
    input logic                              o_last_of_patch,
    input logic                              o_last_of_frame
);

    `PMP_ASSERT(a_hold_valid, i_clk, i_rst_n, o_valid && i_stall |=> o_valid, "result dropped while stalled")
    `PMP_ASSERT(a_frame_in_patch, i_clk, i_rst_n, o_valid && o_last_of_frame |-> o_last_of_patch, "frame end off patch end")
    `PMP_ASSERT(a_index_step, i_clk, i_rst_n, o_valid && !i_stall && !o_last_of_patch |=> o_valid && o_feature_index == pmp_pkg::FIDX_W'($past(o_feature_index) + 1'b1), "kernel index skipped")
    `PMP_ASSERT(a_patch_same, i_clk, i_rst_n, o_valid && !i_stall && !o_last_of_patch |=> o_patch_col_index == $past(o_patch_col_index), "patch changed mid transfer")
    `PMP_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_valid, "result after reset")

endmodule

bind patch_moment_projection_top pmp_checker u_pmp_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_valid           (o_valid),
    .i_stall           (i_stall),
    .o_feature_index   (o_feature_index),
    .o_patch_col_index (o_patch_col_index),
    .o_last_of_patch   (o_last_of_patch),
    .o_last_of_frame   (o_last_of_frame)
);

// ===== bench/tb_patch_moment_projection_top.sv =====
// ----------------------------------------------------------------------------
// Patch moment projection testbench
// Loads kernel tables, streams small raster frames through several register
// settings, and checks every feature sum against a local patch predictor.
// ----------------------------------------------------------------------------
module tb_patch_moment_projection_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                              command;
        logic [pmp_pkg::PIX_W-1:0]         pixel;
        logic [pmp_pkg::SEL_W-1:0]         ksel;
        logic [pmp_pkg::KPOS_W-1:0]        krow;
        logic [pmp_pkg::KPOS_W-1:0]        kcol;
        logic signed [pmp_pkg::COEF_W-1:0] kval;
    } t_item;

    typedef struct packed {
        logic signed [pmp_pkg::FV_W-1:0] fvalue;
        logic [pmp_pkg::FIDX_W-1:0]      findex;
        logic [pmp_pkg::PIDX_W-1:0]      prow;
        logic [pmp_pkg::PIDX_W-1:0]      pcol;
        logic                            lpatch;
        logic                            lframe;
    } t_feature;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int TABLE_SPAN     = 3;
    localparam int ITEM_TARGET    = 320;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [pmp_pkg::CFG_IW-1:0] i_cfg_index = '0;
    logic [pmp_pkg::CFG_DW-1:0] i_cfg_data = '0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic i_command = 1'b0;
    logic [pmp_pkg::PIX_W-1:0] i_pixel_value = '0;
    logic [pmp_pkg::SEL_W-1:0] i_kernel_select = '0;
    logic [pmp_pkg::KPOS_W-1:0] i_kernel_row = '0;
    logic [pmp_pkg::KPOS_W-1:0] i_kernel_col = '0;
    logic signed [pmp_pkg::COEF_W-1:0] i_kernel_value = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic signed [pmp_pkg::FV_W-1:0] o_feature_value;
    logic [pmp_pkg::FIDX_W-1:0] o_feature_index;
    logic [pmp_pkg::PIDX_W-1:0] o_patch_row_index;
    logic [pmp_pkg::PIDX_W-1:0] o_patch_col_index;
    logic o_last_of_patch;
    logic o_last_of_frame;

    patch_moment_projection_top dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predictor state
    int unsigned img_w, img_h, psize, nfeat;
    logic signed [pmp_pkg::COEF_W-1:0] kernels [8][16][16];
    longint sums [8][512];
    int unsigned pix_col, pix_row, off_col, off_row, patch_col, patch_row;

    t_item    pending_items[$];
    t_feature expected_features[$];
    int errors = 0;
    int n_results = 0;
    int n_pixels = 0;
    int n_loads = 0;
    int n_queued = 0;
    bit drv_gap = 0;
    int in_gap = 0;
    int out_gap = 0;
    int watchdog = 0;

    function automatic int unsigned sat(int unsigned v, int unsigned lo, int unsigned hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic void restart_raster();
        pix_col = 0; pix_row = 0; off_col = 0; off_row = 0;
        patch_col = 0; patch_row = 0;
    endfunction

    function automatic void project_item(t_item it);
        int unsigned pcols, prows;
        bit first, last, fin;
        t_feature f;
        if (!it.command) begin
            kernels[it.ksel][it.krow][it.kcol] = it.kval;
            return;
        end
        pcols = img_w / psize;
        prows = img_h / psize;
        if (patch_col < pcols && patch_row < prows) begin
            first = (off_col == 0 && off_row == 0);
            last = (off_col == psize - 1 && off_row == psize - 1);
            for (int k = 0; k < nfeat; k++) begin
                longint term;
                term = longint'(it.pixel) * longint'(kernels[k][off_row][off_col]);
                sums[k][patch_col] = first ? term : sums[k][patch_col] + term;
            end
            if (last) begin
                for (int k = 0; k < nfeat; k++) begin
                    fin = (k + 1 == nfeat);
                    f.fvalue = sums[k][patch_col][pmp_pkg::FV_W-1:0];
                    f.findex = k[pmp_pkg::FIDX_W-1:0];
                    f.prow = patch_row[pmp_pkg::PIDX_W-1:0];
                    f.pcol = patch_col[pmp_pkg::PIDX_W-1:0];
                    f.lpatch = fin;
                    f.lframe = fin && patch_col == pcols - 1 && patch_row == prows - 1;
                    expected_features.insert(expected_features.size(), f);
                end
            end
        end
        pix_col++; off_col++;
        if (off_col >= psize) begin off_col = 0; patch_col++; end
        if (pix_col >= img_w) begin
            pix_col = 0; off_col = 0; patch_col = 0;
            pix_row++; off_row++;
            if (off_row >= psize) begin off_row = 0; patch_row++; end
            if (pix_row >= img_h) restart_raster();
        end
    endfunction

    function automatic int gap_len();
        return ($urandom_range(0, 9) < 7) ? 0 : (($urandom_range(0, 9) < 8)
            ? $urandom_range(1, 3) : $urandom_range(8, 30));
    endfunction

    // driver: present queued items, hold while stalled, idle for random gaps between transfers
    always @(posedge i_clk) begin
        t_item it;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                project_item({i_command, i_pixel_value, i_kernel_select,
                              i_kernel_row, i_kernel_col, i_kernel_value});
                if (i_command) n_pixels++; else n_loads++;
            end
            if (!i_valid || !o_stall) begin
                if (pending_items.size() > 0 && in_gap == 0) begin
                    it = pending_items.pop_front();
                    i_valid <= 1'b1;
                    i_command <= it.command;
                    i_pixel_value <= it.pixel;
                    i_kernel_select <= it.ksel;
                    i_kernel_row <= it.krow;
                    i_kernel_col <= it.kcol;
                    i_kernel_value <= it.kval;
                    in_gap <= drv_gap ? 0 : gap_len();
                end else begin
                    i_valid <= 1'b0;
                    if (in_gap > 0) in_gap <= in_gap - 1;
                end
            end
        end
    end

    // monitor: compare transfers, stall the result channel in bursts
    always @(posedge i_clk) begin
        t_feature e;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                n_results++;
                if (expected_features.size() == 0) begin
                    $error("unexpected feature result");
                    errors++;
                end else begin
                    e = expected_features.pop_front();
                    if (o_feature_value !== e.fvalue) begin
                        $error("feature_value exp %0d got %0d", e.fvalue, o_feature_value);
                        errors++;
                    end
                    if (o_feature_index !== e.findex) begin
                        $error("feature_index exp %0d got %0d", e.findex, o_feature_index);
                        errors++;
                    end
                    if (o_patch_row_index !== e.prow) begin
                        $error("patch_row_index exp %0d got %0d", e.prow, o_patch_row_index);
                        errors++;
                    end
                    if (o_patch_col_index !== e.pcol) begin
                        $error("patch_col_index exp %0d got %0d", e.pcol, o_patch_col_index);
                        errors++;
                    end
                    if (o_last_of_patch !== e.lpatch) begin
                        $error("last_of_patch exp %0d got %0d", e.lpatch, o_last_of_patch);
                        errors++;
                    end
                    if (o_last_of_frame !== e.lframe) begin
                        $error("last_of_frame exp %0d got %0d", e.lframe, o_last_of_frame);
                        errors++;
                    end
                end
            end
            if (out_gap > 0) begin
                i_stall <= 1'b1;
                out_gap <= out_gap - 1;
            end else begin
                i_stall <= 1'b0;
                out_gap <= gap_len();
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) watchdog <= 0;
            else if (pending_items.size() > 0 || expected_features.size() > 0 || i_valid)
                watchdog <= watchdog + 1;
            if (watchdog >= WATCHDOG_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // occasional runs with no input idling
    always @(posedge i_clk) drv_gap <= ($urandom_range(0, 63) < 8) ? ~drv_gap : drv_gap;

    task automatic wait_drained();
        while (pending_items.size() > 0 || i_valid || expected_features.size() > 0)
            @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [pmp_pkg::CFG_IW-1:0] idx, int unsigned val);
        wait_drained();
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val[pmp_pkg::CFG_DW-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            pmp_pkg::REG_IMAGE_WIDTH:     img_w = sat(val, 1, 1024);
            pmp_pkg::REG_IMAGE_HEIGHT:    img_h = sat(val, 1, 1024);
            pmp_pkg::REG_PATCH_SIZE:      psize = sat(val, 2, 16);
            pmp_pkg::REG_FEATURES_IN_USE: nfeat = sat(val, 1, 8);
            default: ;
        endcase
        restart_raster();
    endtask

    function automatic void queue_load(int s, int r, int c, int v);
        t_item it;
        it = '0;
        it.ksel = s[pmp_pkg::SEL_W-1:0];
        it.krow = r[pmp_pkg::KPOS_W-1:0];
        it.kcol = c[pmp_pkg::KPOS_W-1:0];
        it.kval = v[pmp_pkg::COEF_W-1:0];
        pending_items.insert(pending_items.size(), it);
        n_queued++;
    endfunction

    function automatic void queue_pixel(int p);
        t_item it;
        it = t_item'($urandom());
        it.command = 1'b1;
        it.pixel = p[pmp_pkg::PIX_W-1:0];
        pending_items.insert(pending_items.size(), it);
        n_queued++;
    endfunction

    task automatic random_frame(int unsigned w, int unsigned h, int unsigned ps,
                                int unsigned nf, int npix);
        write_reg(pmp_pkg::REG_IMAGE_WIDTH, w);
        write_reg(pmp_pkg::REG_IMAGE_HEIGHT, h);
        write_reg(pmp_pkg::REG_PATCH_SIZE, ps);
        write_reg(pmp_pkg::REG_FEATURES_IN_USE, nf);
        for (int i = 0; i < npix; i++) begin
            // sprinkle coefficient reloads into the pixel stream
            if ($urandom_range(0, 19) == 0)
                queue_load($urandom_range(0, 7), $urandom_range(0, 15),
                           $urandom_range(0, 15), $urandom());
            queue_pixel(($urandom_range(0, 3) == 0) ? 255 * $urandom_range(0, 1)
                                                      : $urandom_range(0, 255));
        end
    endtask

    initial begin
        img_w = pmp_pkg::RST_WIDTH;
        img_h = pmp_pkg::RST_HEIGHT;
        psize = pmp_pkg::RST_PATCH;
        nfeat = pmp_pkg::RST_FEATURES;
        restart_raster();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // fill every coefficient that patches of up to three pixels read
        for (int s = 0; s < 8; s++)
            for (int r = 0; r < TABLE_SPAN; r++)
                for (int c = 0; c < TABLE_SPAN; c++)
                    queue_load(s, r, c, (r == 0 && c == 0) ? 16'sh7FFF :
                               (r == 1 && c == 0) ? 16'sh8000 : $urandom());

        // directed: extreme pixels, minimum patch, one kernel, then all kernels
        random_frame(2, 2, 2, 1, 0);
        queue_pixel(255); queue_pixel(0); queue_pixel(255); queue_pixel(255);
        random_frame(5, 4, 2, 8, 0);
        for (int i = 0; i < 20; i++) queue_pixel(i[0] ? 255 : 0);

        // out of range register values saturate so that no complete patch fits, then an in-range frame
        random_frame(0, 2047, 1, 15, 6);
        random_frame(2047, 0, 31, 0, 12);
        random_frame(6, 6, 3, 3, 36);

        // random settings, small frames
        while (n_queued < ITEM_TARGET) begin
            random_frame($urandom_range(2, 8), $urandom_range(2, 8),
                         $urandom_range(2, TABLE_SPAN), $urandom_range(1, 8),
                         $urandom_range(10, 40));
        end
        wait_drained();
        repeat (20) @(posedge i_clk);
        $display("covered %0d pixels, %0d coefficient loads, %0d feature results",
                 n_pixels, n_loads, n_results);
        if (errors == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+hdl
hdl/pmp_pkg.sv
hdl/patch_moment_projection_top.sv
hdl/pmp_checker.sv
bench/tb_patch_moment_projection_top.sv
